/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the request queue.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define DIOQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("request queue assertion failed");

// Same-cycle implication.
`define DIOQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `DIOQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define DIOQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `DIOQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

/* rtl/dioq_pkg.sv */
// Shared types and constants of the deadline I/O request queue.
// Used by the controller, the datapath, the top level and the checker.
package dioq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  localparam int unsigned SECTOR_W   = 48;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned DEADLINE_W = 48;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic {
    KIND_SUBMIT   = 1'b0,
    KIND_DISPATCH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_SCAN,
    S_INS_PUT,
    S_DISP_OUT,
    S_FINISH
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_TAIL,
    RD_NEXT,
    RD_HEAD
  } rd_sel_e;

  typedef enum logic {
    WR_NEW,
    WR_SHIFT
  } wr_src_e;

  typedef struct packed {
    logic [SECTOR_W-1:0]   sector;
    logic [COUNT_W-1:0]    count;
    logic [DEADLINE_W-1:0] deadline;
    logic [TAG_W-1:0]      tag;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_src_e wr_src;
    logic    i_load;
    logic    i_dec;
    logic    fill_inc;
    logic    fill_dec;
    logic    head_adv;
    logic    status_load;
    status_e status_val;
    logic    out_load;
  } dioq_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  i_is_one;
    logic  later;
    logic  out_free;
  } dioq_stat_t;

endpackage

/* rtl/deadline_io_request_queue.sv */
// Deadline I/O request queue, one item at a time: a new item is taken only after
// the result of the last one is loaded, and a stalled result holds the load back.
// A dispatch reads the head entry of its queue. A submit to a full queue is refused;
// other submits walk back over the k queued entries with a later deadline (at most
// QUEUE_DEPTH - 1), shifting one entry a cycle, and then put the new item in the gap.
// Reset clears fill counts, head pointers and control; entries stay.
module deadline_io_request_queue
  import dioq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [SECTOR_W-1:0]   sector_i,
  input  logic [COUNT_W-1:0]    sector_count_i,
  input  logic                  is_read_i,
  input  logic [DEADLINE_W-1:0] deadline_i,
  input  logic [TAG_W-1:0]      tag_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SECTOR_W-1:0]   out_sector_o,
  output logic [COUNT_W-1:0]    out_count_o,
  output logic                  out_is_read_o,
  output logic [DEADLINE_W-1:0] out_deadline_o,
  output logic [TAG_W-1:0]      out_tag_o
);

  // Each queue is a ring in its own half of the entry memory, kept sorted
  // by deadline from the head. A submit walks back from the tail, moving
  // each later entry one slot down, and drops the new item into the gap.
  // A dispatch reads the head of the read queue (or of the write queue
  // when no read is pending) and advances that head pointer.
  dioq_cmd_t  cmd;
  dioq_stat_t stat;

  dioq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dioq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .sector_i       (sector_i),
    .sector_count_i (sector_count_i),
    .is_read_i      (is_read_i),
    .deadline_i     (deadline_i),
    .tag_i          (tag_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_sector_o   (out_sector_o),
    .out_count_o    (out_count_o),
    .out_is_read_o  (out_is_read_o),
    .out_deadline_o (out_deadline_o),
    .out_tag_o      (out_tag_o)
  );

endmodule

/* rtl/dioq_ctrl.sv */
// Controller of the request queue: sequences submit and dispatch items.
// Depends on dioq_pkg; drives the datapath through dioq_cmd_t.
module dioq_ctrl
  import dioq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dioq_stat_t stat_i,
  output dioq_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.kind == KIND_SUBMIT) begin
          if (stat_i.full) begin
            cmd_o.status_load = 1'b1;
            cmd_o.status_val  = ST_FULL;
            state_d           = S_FINISH;
          end else begin
            cmd_o.i_load = 1'b1;
            if (stat_i.empty) begin
              state_d = S_INS_PUT;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_TAIL;
              state_d      = S_INS_SCAN;
            end
          end
        end else begin
          if (stat_i.empty) begin
            cmd_o.status_load = 1'b1;
            cmd_o.status_val  = ST_EMPTY;
            state_d           = S_FINISH;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_HEAD;
            state_d      = S_DISP_OUT;
          end
        end
      end
      S_INS_SCAN: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.later) begin
          // move the later entry one slot toward the tail
          cmd_o.wr_src = WR_SHIFT;
          cmd_o.i_dec  = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          if (stat_i.i_is_one) begin
            state_d = S_INS_PUT;
          end
        end else begin
          cmd_o.wr_src      = WR_NEW;
          cmd_o.fill_inc    = 1'b1;
          cmd_o.status_load = 1'b1;
          cmd_o.status_val  = ST_ACCEPTED;
          state_d           = S_FINISH;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_src      = WR_NEW;
        cmd_o.fill_inc    = 1'b1;
        cmd_o.status_load = 1'b1;
        cmd_o.status_val  = ST_ACCEPTED;
        state_d           = S_FINISH;
      end
      S_DISP_OUT: begin
        cmd_o.head_adv    = 1'b1;
        cmd_o.fill_dec    = 1'b1;
        cmd_o.status_load = 1'b1;
        cmd_o.status_val  = ST_DISPATCHED;
        state_d           = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dioq_dp.sv */
// Datapath of the request queue: entry memory, fill and head pointers,
// item registers and the result register. Depends on dioq_pkg.
module dioq_dp
  import dioq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  kind_i,
  input  logic [SECTOR_W-1:0]   sector_i,
  input  logic [COUNT_W-1:0]    sector_count_i,
  input  logic                  is_read_i,
  input  logic [DEADLINE_W-1:0] deadline_i,
  input  logic [TAG_W-1:0]      tag_i,
  input  dioq_cmd_t             cmd_i,
  output dioq_stat_t            stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SECTOR_W-1:0]   out_sector_o,
  output logic [COUNT_W-1:0]    out_count_o,
  output logic                  out_is_read_o,
  output logic [DEADLINE_W-1:0] out_deadline_o,
  output logic [TAG_W-1:0]      out_tag_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // Ring slot of a position counted from the head.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] rel);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(rel);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  entry_t        mem_q [2][QUEUE_DEPTH];
  entry_t        rd_data_q;
  entry_t        new_q;
  kind_e         kind_q;
  logic          q_q;
  logic [CW-1:0] i_q;
  logic [CW-1:0] read_fill_q, write_fill_q;
  logic [AW-1:0] read_head_q, write_head_q;
  status_e       status_q;

  logic [CW-1:0] cur_fill;
  logic [AW-1:0] cur_head, head_nxt, rd_addr, wr_addr;
  logic [CW-1:0] rd_rel;
  entry_t        wr_data;
  logic          out_free;

  assign cur_fill = q_q ? read_fill_q : write_fill_q;
  assign cur_head = q_q ? read_head_q : write_head_q;
  assign head_nxt = (cur_head == AW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + AW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_TAIL: rd_rel = cur_fill - CW'(1);
      RD_NEXT: rd_rel = (i_q >= CW'(2)) ? i_q - CW'(2) : '0;
      RD_HEAD: rd_rel = '0;
      default: rd_rel = '0;
    endcase
  end

  assign rd_addr = slot_of(cur_head, rd_rel);
  assign wr_addr = slot_of(cur_head, i_q);
  assign wr_data = (cmd_i.wr_src == WR_SHIFT) ? rd_data_q : new_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[q_q][wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[q_q][rd_addr];
    end
  end

  // Item registers; the dispatch queue is settled here while fills are idle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q         <= kind_e'(kind_i);
      q_q            <= kind_i ? (read_fill_q != '0) : is_read_i;
      new_q.sector   <= sector_i;
      new_q.count    <= sector_count_i;
      new_q.deadline <= deadline_i;
      new_q.tag      <= tag_i;
    end
    if (cmd_i.i_load) begin
      i_q <= cur_fill;
    end else if (cmd_i.i_dec) begin
      i_q <= i_q - CW'(1);
    end
    if (cmd_i.status_load) begin
      status_q <= cmd_i.status_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_fill_q  <= '0;
      write_fill_q <= '0;
      read_head_q  <= '0;
      write_head_q <= '0;
    end else begin
      if (cmd_i.fill_inc) begin
        if (q_q) read_fill_q <= read_fill_q + CW'(1);
        else     write_fill_q <= write_fill_q + CW'(1);
      end else if (cmd_i.fill_dec) begin
        if (q_q) read_fill_q <= read_fill_q - CW'(1);
        else     write_fill_q <= write_fill_q - CW'(1);
      end
      if (cmd_i.head_adv) begin
        if (q_q) read_head_q <= head_nxt;
        else     write_head_q <= head_nxt;
      end
    end
  end

  // Result register
  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o <= status_q;
      if (status_q == ST_DISPATCHED) begin
        out_sector_o   <= rd_data_q.sector;
        out_count_o    <= rd_data_q.count;
        out_is_read_o  <= q_q;
        out_deadline_o <= rd_data_q.deadline;
        out_tag_o      <= rd_data_q.tag;
      end else begin
        out_sector_o   <= '0;
        out_count_o    <= '0;
        out_is_read_o  <= 1'b0;
        out_deadline_o <= '0;
        out_tag_o      <= '0;
      end
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.full     = (cur_fill == CW'(QUEUE_DEPTH));
  assign stat_o.empty    = (cur_fill == '0);
  assign stat_o.i_is_one = (i_q == CW'(1));
  assign stat_o.later    = (rd_data_q.deadline > new_q.deadline);
  assign stat_o.out_free = out_free;

endmodule

/* rtl/dioq_checker.sv */
// Port-level checks of the request queue, bound to the top level.
// Depends on dioq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dioq_checker
  import dioq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [STATUS_W-1:0]   status_o,
  input logic [SECTOR_W-1:0]   out_sector_o,
  input logic [COUNT_W-1:0]    out_count_o,
  input logic                  out_is_read_o,
  input logic [DEADLINE_W-1:0] out_deadline_o,
  input logic [TAG_W-1:0]      out_tag_o
);

  // Busy right after taking an item.
  `DIOQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A fresh result always leaves the item side ready.
  `DIOQ_ASSERT_IMP(a_ready_with_result, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

  // Only dispatched results carry request fields.
  `DIOQ_ASSERT_IMP(a_zero_fields, clk_i, rst_ni, out_valid_o && (status_o != ST_DISPATCHED), (out_sector_o == '0) && (out_count_o == '0) && !out_is_read_o && (out_deadline_o == '0) && (out_tag_o == '0))

  // Hold a stalled result.
  `DIOQ_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(out_sector_o) && $stable(out_count_o) && $stable(out_is_read_o) && $stable(out_deadline_o) && $stable(out_tag_o))

endmodule

bind deadline_io_request_queue dioq_checker u_dioq_checker (.*);
